// ----- hw/rtl/pat_pkg.sv -----
// Shared types, constants and command codes for the peer address table.
package pat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_ANNOUNCE = 2'd0;
    localparam logic [1:0] CMD_EXPIRE   = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;

    localparam logic [2:0] OUT_EMPTY   = 3'd0;
    localparam logic [2:0] OUT_OWN     = 3'd1;
    localparam logic [2:0] OUT_UPDATED = 3'd2;
    localparam logic [2:0] OUT_CREATED = 3'd3;
    localparam logic [2:0] OUT_EVICTED = 3'd4;
    localparam logic [2:0] OUT_EXPIRED = 3'd5;
    localparam logic [2:0] OUT_READ_OK = 3'd6;
    localparam logic [2:0] OUT_READ_BAD = 3'd7;

    localparam logic [1:0] REG_DEFAULT_PORT = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS  = 2'd1;
    localparam logic [1:0] REG_OWN_PORT     = 2'd2;
    localparam logic [1:0] REG_TIMEOUT      = 2'd3;

    // Kind of work the back end carries out for one transaction.
    localparam logic [1:0] JOB_FIXED  = 2'd0;
    localparam logic [1:0] JOB_ANNOUNCE = 2'd1;
    localparam logic [1:0] JOB_EXPIRE = 2'd2;
    localparam logic [1:0] JOB_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]  job;
        logic [2:0]  outcome;
        logic [31:0] address;
        logic [15:0] port;
        logic        status;
        logic        skeleton;
        logic [31:0] now;
        logic [3:0]  index;
    } job_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [3:0]  slot;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] last_seen;
        logic        status;
        logic        skeleton;
        logic [4:0]  count;
    } result_t;

endpackage

// ----- hw/rtl/pat_front.sv -----
// Front end: accepts transactions, applies the port default and loopback filter.
module pat_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_command,
    input  logic [31:0]    s_ip_address,
    input  logic [15:0]    s_port_value,
    input  logic           s_status_changed,
    input  logic           s_skeleton_changed,
    input  logic [31:0]    s_now_ms,
    input  logic [3:0]     s_entry_index,
    input  logic [15:0]    default_port,
    input  logic [31:0]    own_address,
    input  logic [15:0]    own_port,
    output logic           job_valid,
    input  logic           job_ready,
    output pat_pkg::job_t  job
);
    import pat_pkg::*;

    job_t job_reg, job_next;
    logic full_reg;
    logic [15:0] port_eff;

    assign s_ready = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job = job_reg;
    assign port_eff = (s_port_value == 16'd0) ? default_port : s_port_value;

    always_comb begin
        job_next = '0;
        job_next.address = s_ip_address;
        job_next.port = port_eff;
        job_next.status = s_status_changed;
        job_next.skeleton = s_skeleton_changed;
        job_next.now = s_now_ms;
        job_next.index = s_entry_index;
        unique case (s_command)
            CMD_ANNOUNCE: begin
                if (s_ip_address == 32'd0) begin
                    job_next.job = JOB_FIXED;
                    job_next.outcome = OUT_EMPTY;
                end else if (s_ip_address == own_address && port_eff == own_port) begin
                    job_next.job = JOB_FIXED;
                    job_next.outcome = OUT_OWN;
                end else begin
                    job_next.job = JOB_ANNOUNCE;
                end
            end
            CMD_EXPIRE: job_next.job = JOB_EXPIRE;
            default:    job_next.job = JOB_READ;
        endcase
        if (s_command != CMD_READ && s_command != CMD_ANNOUNCE &&
            s_command != CMD_EXPIRE) begin
            job_next.job = JOB_FIXED;
            job_next.outcome = OUT_READ_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            full_reg <= 1'b1;
        end else if (job_ready) begin
            full_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("queued job changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job.job == JOB_FIXED |-> job.outcome <= OUT_OWN ||
        job.outcome == OUT_READ_BAD)
        else $error("fixed job with bad outcome");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !full_reg |-> s_ready)
        else $error("empty front end not ready");

endmodule

// ----- hw/rtl/pat_back.sv -----
// Back end: reads an entry, or scans one per cycle to add, update, evict or expire.
module pat_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  pat_pkg::job_t    job,
    input  logic [31:0]      expiry_timeout,
    output logic             m_valid,
    input  logic             m_ready,
    output pat_pkg::result_t res
);
    import pat_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SHOW  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [31:0] addr_mem [TABLE_DEPTH];
    logic [15:0] port_mem [TABLE_DEPTH];
    logic [31:0] seen_mem [TABLE_DEPTH];
    logic        st_mem   [TABLE_DEPTH];
    logic        sk_mem   [TABLE_DEPTH];

    logic [2:0]       state_reg;
    job_t             job_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] wptr_reg;
    logic [IDX_W-1:0] hit_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] old_reg;
    logic [31:0]      old_seen_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [2:0]       outcome_reg;
    logic             show_reg;
    result_t          res_reg;
    logic             out_full_reg;

    logic [IDX_W-1:0] p;
    logic [31:0]      age;

    assign p = ptr_reg[IDX_W-1:0];
    assign age = job_reg.now - seen_mem[p];
    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid = out_full_reg;
    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            out_full_reg <= 1'b0;
        end else begin
            if (state_reg == ST_SHOW && (!out_full_reg || m_ready)) begin
                out_full_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_full_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        ptr_reg <= '0;
                        wptr_reg <= '0;
                        hit_found_reg <= 1'b0;
                        old_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (job_reg.job == JOB_FIXED) begin
                        outcome_reg <= job_reg.outcome;
                        slot_reg <= (job_reg.outcome == OUT_READ_BAD) ?
                            job_reg.index[IDX_W-1:0] : '0;
                        show_reg <= 1'b0;
                        state_reg <= ST_SHOW;
                    end else if (job_reg.job == JOB_READ) begin
                        slot_reg <= job_reg.index[IDX_W-1:0];
                        if ({1'b0, job_reg.index} < count_reg) begin
                            outcome_reg <= OUT_READ_OK;
                            show_reg <= 1'b1;
                        end else begin
                            outcome_reg <= OUT_READ_BAD;
                            show_reg <= 1'b0;
                        end
                        state_reg <= ST_SHOW;
                    end else if (job_reg.job == JOB_EXPIRE) begin
                        if (ptr_reg < count_reg) begin
                            if (age <= expiry_timeout) begin
                                addr_mem[wptr_reg[IDX_W-1:0]] <= addr_mem[p];
                                port_mem[wptr_reg[IDX_W-1:0]] <= port_mem[p];
                                seen_mem[wptr_reg[IDX_W-1:0]] <= seen_mem[p];
                                st_mem[wptr_reg[IDX_W-1:0]] <= st_mem[p];
                                sk_mem[wptr_reg[IDX_W-1:0]] <= sk_mem[p];
                                wptr_reg <= wptr_reg + 1'b1;
                            end
                            ptr_reg <= ptr_reg + 1'b1;
                        end else begin
                            count_reg <= wptr_reg;
                            outcome_reg <= OUT_EXPIRED;
                            slot_reg <= '0;
                            show_reg <= 1'b0;
                            state_reg <= ST_SHOW;
                        end
                    end else begin
                        if (ptr_reg < count_reg && !hit_found_reg) begin
                            if (addr_mem[p] == job_reg.address &&
                                port_mem[p] == job_reg.port) begin
                                hit_found_reg <= 1'b1;
                                hit_reg <= p;
                            end
                            if (ptr_reg == '0 || seen_mem[p] < old_seen_reg) begin
                                old_reg <= p;
                                old_seen_reg <= seen_mem[p];
                            end
                            ptr_reg <= ptr_reg + 1'b1;
                        end else begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_WRITE: begin
                    if (hit_found_reg) begin
                        slot_reg <= hit_reg;
                        outcome_reg <= OUT_UPDATED;
                    end else if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                        slot_reg <= count_reg[IDX_W-1:0];
                        count_reg <= count_reg + 1'b1;
                        outcome_reg <= OUT_CREATED;
                    end else begin
                        slot_reg <= old_reg;
                        outcome_reg <= OUT_EVICTED;
                    end
                    show_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    addr_mem[slot_reg] <= job_reg.address;
                    port_mem[slot_reg] <= job_reg.port;
                    seen_mem[slot_reg] <= job_reg.now;
                    st_mem[slot_reg] <= job_reg.status;
                    sk_mem[slot_reg] <= job_reg.skeleton;
                    state_reg <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (!out_full_reg || m_ready) begin
                        res_reg.outcome <= outcome_reg;
                        res_reg.slot <= 4'(slot_reg);
                        res_reg.count <= 5'(count_reg);
                        res_reg.address <= show_reg ? addr_mem[slot_reg] : '0;
                        res_reg.port <= show_reg ? port_mem[slot_reg] : '0;
                        res_reg.last_seen <= show_reg ? seen_mem[slot_reg] : '0;
                        res_reg.status <= show_reg ? st_mem[slot_reg] : 1'b0;
                        res_reg.skeleton <= show_reg ? sk_mem[slot_reg] : 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(res))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && job_reg.job == JOB_EXPIRE |-> wptr_reg <= ptr_reg)
        else $error("compaction write pointer ahead of read pointer");

endmodule

// ----- hw/rtl/peer_address_table_oldest_evict.sv -----
// Top level of the peer address table with oldest-entry eviction.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    command, address, port, flags, time, index
//  m_       out        m_valid / m_ready    outcome, slot, entry fields, entry count
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From acceptance to a valid result, a job passes the front-end queue and the idle state;
// an announce then goes through scan, write, out and show, and an expire through scan and
// show, one entry per cycle in scan. A read or a filtered announce goes from scan to show.
// Reset empties the table at once; there is no clearing pass.
// A one-entry queue lets the front end take a transaction while the back end works.
module peer_address_table_oldest_evict (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_ip_address,
    input  logic [15:0] s_port_value,
    input  logic        s_status_changed,
    input  logic        s_skeleton_changed,
    input  logic [31:0] s_now_ms,
    input  logic [3:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [3:0]  m_slot,
    output logic [31:0] m_out_address,
    output logic [15:0] m_out_port,
    output logic [31:0] m_out_last_seen,
    output logic        m_out_status_changed,
    output logic        m_out_skeleton_changed,
    output logic [4:0]  m_entry_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pat_pkg::*;

    logic [15:0] default_port_reg;
    logic [31:0] own_address_reg;
    logic [15:0] own_port_reg;
    logic [31:0] timeout_reg;
    logic        job_valid;
    logic        job_ready;
    job_t        job;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_port_reg <= 16'd80;
            own_address_reg <= 32'd0;
            own_port_reg <= 16'd80;
            timeout_reg <= 32'd30000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEFAULT_PORT: default_port_reg <= cfg_data[15:0];
                REG_OWN_ADDRESS:  own_address_reg <= cfg_data;
                REG_OWN_PORT:     own_port_reg <= cfg_data[15:0];
                REG_TIMEOUT:      timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pat_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_ip_address(s_ip_address),
        .s_port_value(s_port_value), .s_status_changed(s_status_changed),
        .s_skeleton_changed(s_skeleton_changed), .s_now_ms(s_now_ms),
        .s_entry_index(s_entry_index),
        .default_port(default_port_reg), .own_address(own_address_reg),
        .own_port(own_port_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    pat_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .expiry_timeout(timeout_reg),
        .m_valid(m_valid), .m_ready(m_ready), .res(res)
    );

    assign m_outcome = res.outcome;
    assign m_slot = res.slot;
    assign m_out_address = res.address;
    assign m_out_port = res.port;
    assign m_out_last_seen = res.last_seen;
    assign m_out_status_changed = res.status;
    assign m_out_skeleton_changed = res.skeleton;
    assign m_entry_count = res.count;

endmodule
